>>> design/fce_pkg.sv
package fce_pkg;

  localparam int TABLE_ENTRIES = 8192;
  localparam int ADDR_W        = $clog2(TABLE_ENTRIES);
  localparam int LINK_W        = 16;
  localparam int CNT_W         = 14;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [LINK_W-1:0] link_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  localparam link_t END_LINK  = 16'hFFFF;
  localparam link_t FREE_LINK = 16'h0000;

  localparam logic [2:0] KIND_FIND   = 3'd0;
  localparam logic [2:0] KIND_APPEND = 3'd1;
  localparam logic [2:0] KIND_FREE   = 3'd2;
  localparam logic [2:0] KIND_LOAD   = 3'd3;
  localparam logic [2:0] KIND_READ   = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_PAST    = 2'd1;
  localparam logic [1:0] ST_NO_FREE = 2'd2;
  localparam logic [1:0] ST_RANGE   = 2'd3;

  typedef struct packed {
    logic  we;
    addr_t addr;
    link_t data;
  } mem_wr_t;

endpackage

>>> design/fce_link_mem.sv
module fce_link_mem (
  input  logic            clk,
  input  fce_pkg::mem_wr_t wr,
  input  fce_pkg::addr_t  raddr,
  output fce_pkg::link_t  rdata
);
  import fce_pkg::*;

  link_t mem [TABLE_ENTRIES];
  link_t rdata_r;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> design/fat_chain_engine.sv
// Load writes one table entry, read returns one entry, unused kinds give an empty result.
// Find walks the chain from its head to the asked position. Free clears each chain block.
// Append scans the table for a free entry, then walks a non-empty chain to link it on.
// One item at a time; every table visit is an address state then a data state on the single read port.
// Reset (rst_n low, synchronous) starts a clearing pass that zeroes the table;
// no input is taken until it ends. Config writes always taken.
module fat_chain_engine (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // kind[2:0], chain_head[18:3], block_position[34:19], entry_index[47:35],
  // entry_value[63:48]
  input  logic [63:0]            in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // block_number[15:0], status[17:16], zero fill above
  output logic [23:0]            out_tdata,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [fce_pkg::CNT_W-1:0] cfg_data
);
  import fce_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DISPATCH, S_FIND, S_FIND_DATA, S_SRCH, S_SRCH_DATA,
    S_WALK, S_WALK_DATA, S_FREE, S_FREE_DATA, S_RD_DATA, S_RESULT
  } state_t;

  state_t     state_r, state_nxt;
  addr_t      clr_cnt_r, clr_cnt_nxt;
  cnt_t       dbc_r, dbc_nxt;
  logic       out_valid_r, out_valid_nxt;
  link_t      out_blk_r, out_blk_nxt;
  logic [1:0] out_st_r, out_st_nxt;
  link_t      res_blk_r, res_blk_nxt;
  logic [1:0] res_st_r, res_st_nxt;
  logic [2:0] kind_r, kind_nxt;
  link_t      head_r, head_nxt;
  link_t      pos_r, pos_nxt;
  addr_t      idx_r, idx_nxt;
  link_t      val_r, val_nxt;
  link_t      cur_r, cur_nxt;
  link_t      step_r, step_nxt;
  link_t      new_blk_r, new_blk_nxt;

  mem_wr_t    mem_wr;
  addr_t      mem_raddr;
  link_t      mem_rdata;
  cnt_t       lim;
  link_t      lim_ext;
  link_t      step_inc;
  logic       cur_oob;

  fce_link_mem u_mem (
    .clk   (clk),
    .wr    (mem_wr),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign lim      = (dbc_r > CNT_W'(TABLE_ENTRIES)) ? CNT_W'(TABLE_ENTRIES) : dbc_r;
  assign lim_ext  = LINK_W'(lim);
  assign step_inc = step_r + 16'd1;
  assign cur_oob  = (cur_r >= lim_ext);

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_st_r, out_blk_r};

  always_comb begin
    case (state_r)
      S_DISPATCH: mem_raddr = idx_r;
      S_SRCH:     mem_raddr = step_r[ADDR_W-1:0];
      default:    mem_raddr = cur_r[ADDR_W-1:0];
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    dbc_nxt       = dbc_r;
    out_valid_nxt = out_valid_r;
    out_blk_nxt   = out_blk_r;
    out_st_nxt    = out_st_r;
    res_blk_nxt   = res_blk_r;
    res_st_nxt    = res_st_r;
    kind_nxt      = kind_r;
    head_nxt      = head_r;
    pos_nxt       = pos_r;
    idx_nxt       = idx_r;
    val_nxt       = val_r;
    cur_nxt       = cur_r;
    step_nxt      = step_r;
    new_blk_nxt   = new_blk_r;
    mem_wr        = '0;

    if (cfg_valid && cfg_ready) begin
      dbc_nxt = cfg_data;
    end
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_CLEAR: begin
        mem_wr.we   = 1'b1;
        mem_wr.addr = clr_cnt_r;
        mem_wr.data = FREE_LINK;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == addr_t'(TABLE_ENTRIES - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          kind_nxt  = in_tdata[2:0];
          head_nxt  = in_tdata[18:3];
          pos_nxt   = in_tdata[34:19];
          idx_nxt   = in_tdata[47:35];
          val_nxt   = in_tdata[63:48];
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        res_blk_nxt = '0;
        res_st_nxt  = ST_OK;
        cur_nxt     = head_r;
        step_nxt    = '0;
        case (kind_r)
          KIND_FIND: begin
            if (head_r == END_LINK) begin
              res_st_nxt = ST_PAST;
              state_nxt  = S_RESULT;
            end else begin
              state_nxt = S_FIND;
            end
          end
          KIND_APPEND: state_nxt = S_SRCH;
          KIND_FREE:   state_nxt = S_FREE;
          KIND_LOAD: begin
            mem_wr.we   = 1'b1;
            mem_wr.addr = idx_r;
            mem_wr.data = val_r;
            state_nxt   = S_RESULT;
          end
          KIND_READ:   state_nxt = S_RD_DATA;
          default:     state_nxt = S_RESULT;
        endcase
      end
      S_FIND: begin
        if (step_r == pos_r) begin
          res_blk_nxt = cur_r;
          state_nxt   = S_RESULT;
        end else if (cur_oob) begin
          res_st_nxt = ST_RANGE;
          state_nxt  = S_RESULT;
        end else begin
          state_nxt = S_FIND_DATA;
        end
      end
      S_FIND_DATA: begin
        if (mem_rdata == END_LINK) begin
          res_st_nxt = ST_PAST;
          state_nxt  = S_RESULT;
        end else begin
          cur_nxt   = mem_rdata;
          step_nxt  = step_inc;
          state_nxt = S_FIND;
        end
      end
      S_SRCH: begin
        if (step_r >= lim_ext) begin
          res_st_nxt = ST_NO_FREE;
          state_nxt  = S_RESULT;
        end else begin
          state_nxt = S_SRCH_DATA;
        end
      end
      S_SRCH_DATA: begin
        if (mem_rdata == FREE_LINK) begin
          mem_wr.we   = 1'b1;
          mem_wr.addr = step_r[ADDR_W-1:0];
          mem_wr.data = END_LINK;
          new_blk_nxt = step_r;
          step_nxt    = '0;
          if (head_r == END_LINK) begin
            res_blk_nxt = step_r;
            state_nxt   = S_RESULT;
          end else begin
            state_nxt = S_WALK;
          end
        end else begin
          step_nxt  = step_inc;
          state_nxt = S_SRCH;
        end
      end
      S_WALK: begin
        if (cur_oob) begin
          res_st_nxt = ST_RANGE;
          state_nxt  = S_RESULT;
        end else begin
          state_nxt = S_WALK_DATA;
        end
      end
      S_WALK_DATA: begin
        if (mem_rdata == END_LINK) begin
          mem_wr.we   = 1'b1;
          mem_wr.addr = cur_r[ADDR_W-1:0];
          mem_wr.data = new_blk_r;
          res_blk_nxt = new_blk_r;
          state_nxt   = S_RESULT;
        end else if (step_inc > lim_ext) begin
          // looped chain
          res_st_nxt = ST_RANGE;
          state_nxt  = S_RESULT;
        end else begin
          step_nxt  = step_inc;
          cur_nxt   = mem_rdata;
          state_nxt = S_WALK;
        end
      end
      S_FREE: begin
        if (cur_r == END_LINK || cur_r == FREE_LINK) begin
          state_nxt = S_RESULT;
        end else if (cur_oob) begin
          res_st_nxt = ST_RANGE;
          state_nxt  = S_RESULT;
        end else begin
          state_nxt = S_FREE_DATA;
        end
      end
      S_FREE_DATA: begin
        mem_wr.we   = 1'b1;
        mem_wr.addr = cur_r[ADDR_W-1:0];
        mem_wr.data = FREE_LINK;
        cur_nxt     = mem_rdata;
        state_nxt   = S_FREE;
      end
      S_RD_DATA: begin
        res_blk_nxt = mem_rdata;
        state_nxt   = S_RESULT;
      end
      S_RESULT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_blk_nxt   = res_blk_r;
          out_st_nxt    = res_st_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      dbc_r       <= CNT_W'(8192);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      dbc_r       <= dbc_nxt;
      out_valid_r <= out_valid_nxt;
      out_blk_r   <= out_blk_nxt;
      out_st_r    <= out_st_nxt;
      res_blk_r   <= res_blk_nxt;
      res_st_r    <= res_st_nxt;
      kind_r      <= kind_nxt;
      head_r      <= head_nxt;
      pos_r       <= pos_nxt;
      idx_r       <= idx_nxt;
      val_r       <= val_nxt;
      cur_r       <= cur_nxt;
      step_r      <= step_nxt;
      new_blk_r   <= new_blk_nxt;
    end
  end

  a_err_zero_blk: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_st_r != ST_OK) |-> (out_blk_r == '0))
    else $error("nonzero block number on error result");

  a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == S_DISPATCH))
    else $error("accepted transfer not dispatched");

  a_walk_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_WALK_DATA || state_r == S_FREE_DATA) && mem_wr.we)
      |-> (cur_r < lim_ext))
    else $error("chain write beyond block limit");

  a_result_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESULT && out_valid_r && !out_tready) |=> (state_r == S_RESULT))
    else $error("result left before output slot freed");

endmodule
